@@ rtl/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants for the UTF-8 to UTF-16 transcoder
// Result word layout, the decoder's result bundle and the code point limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

   // Code point limits
   localparam logic [20:0] CP_BMP_LOW_MAX  = 21'h00D7FF;
   localparam logic [20:0] CP_BMP_HIGH_MIN = 21'h00E000;
   localparam logic [20:0] CP_BMP_MAX      = 21'h00FFFF;
   localparam logic [20:0] CP_SUPP_MIN     = 21'h010000;
   localparam logic [20:0] CP_MAX          = 21'h10FFFF;

   // Surrogate bases, top six bits of the unit
   localparam logic [5:0] HI_SURR_TAG = 6'b110110;   // 0xD800
   localparam logic [5:0] LO_SURR_TAG = 6'b110111;   // 0xDC00

   // Output queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   // One result word
   typedef struct packed {
      logic [15:0] code_unit;
      logic        bad_sequence;
      logic        run_last;
      logic        string_done;
   } rsp_word_type;

   // Results caused by one input byte: zero, one or two words
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } dec_result_type;

endpackage

`default_nettype wire

@@ rtl/u8u16_ifs.sv @@
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Valid/ready channels for the byte input and the code unit output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        bad_sequence;
   logic        run_last;
   logic        string_done;

   modport source (output valid, output code_unit, output bad_sequence,
                   output run_last, output string_done, input ready);
   modport sink   (input valid, input code_unit, input bad_sequence,
                   input run_last, input string_done, output ready);
endinterface

`default_nettype wire

@@ rtl/u8u16_decode.sv @@
// ----------------------------------------------------------------------------
// u8u16_decode: UTF-8 sequence decoder
// Holds the sequence state and turns one byte into zero, one or two words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8u16_decode
   import u8u16_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire logic [7:0]     in_byte,
   input  wire logic           string_end,
   output dec_result_type      result
);

   logic [1:0]  pending_ff, pending_in;
   logic [20:0] accum_ff, accum_in;
   logic        broken_ff, broken_in;

   logic [20:0] cp_next;
   logic        broken_next;
   logic [19:0] supp_off;
   rsp_word_type w0, w1;
   logic [1:0]  n;

   assign cp_next     = {accum_ff[14:0], in_byte[5:0]};
   assign broken_next = broken_ff | (in_byte[7:6] != 2'b10);
   assign supp_off    = 20'(cp_next - CP_SUPP_MIN);

   // Sequence state and result words
   always_comb begin
      pending_in = pending_ff;
      accum_in   = accum_ff;
      broken_in  = broken_ff;
      w0 = '0;
      w1 = '0;
      n  = 2'd0;

      if (pending_ff == 2'd0) begin
         if (in_byte[7] == 1'b0) begin
            w0.code_unit = {8'h00, in_byte};
            n = 2'd1;
         end else if (in_byte[7:6] == 2'b10 || in_byte[7:3] == 5'b11111) begin
            w0.bad_sequence = 1'b1;
            n = 2'd1;
         end else begin
            // lead byte: remember length and payload bits
            if (in_byte[5] == 1'b0) begin
               pending_in = 2'd1;
               accum_in   = {16'd0, in_byte[4:0]};
            end else if (in_byte[4] == 1'b0) begin
               pending_in = 2'd2;
               accum_in   = {17'd0, in_byte[3:0]};
            end else begin
               pending_in = 2'd3;
               accum_in   = {18'd0, in_byte[2:0]};
            end
            broken_in = 1'b0;
         end
      end else begin
         pending_in = pending_ff - 2'd1;
         accum_in   = cp_next;
         broken_in  = broken_next;
         if (pending_ff == 2'd1) begin
            // sequence complete: check and encode
            n = 2'd1;
            if (broken_next) begin
               w0.bad_sequence = 1'b1;
            end else if (cp_next <= CP_BMP_LOW_MAX ||
                         (cp_next >= CP_BMP_HIGH_MIN && cp_next <= CP_BMP_MAX)) begin
               w0.code_unit = cp_next[15:0];
            end else if (cp_next >= CP_SUPP_MIN && cp_next <= CP_MAX) begin
               w0.code_unit = {HI_SURR_TAG, supp_off[19:10]};
               w1.code_unit = {LO_SURR_TAG, supp_off[9:0]};
               n = 2'd2;
            end else begin
               w0.bad_sequence = 1'b1;
            end
            accum_in  = '0;
            broken_in = 1'b0;
         end
      end

      // end of string: a cut-off sequence gives one error word
      if (string_end) begin
         if (pending_in != 2'd0) begin
            w0 = '0;
            w1 = '0;
            w0.bad_sequence = 1'b1;
            n = 2'd1;
         end
         pending_in = 2'd0;
         accum_in   = '0;
         broken_in  = 1'b0;
      end

      // mark the last word of this byte
      if (n == 2'd2) begin
         w1.run_last    = 1'b1;
         w1.string_done = string_end;
      end else if (n == 2'd1) begin
         w0.run_last    = 1'b1;
         w0.string_done = string_end;
      end
   end

   assign result.count  = n;
   assign result.first  = w0;
   assign result.second = w1;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         accum_ff   <= '0;
         broken_ff  <= 1'b0;
      end else if (step) begin
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
         broken_ff  <= broken_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/u8u16_queue.sv @@
// ----------------------------------------------------------------------------
// u8u16_queue: result word queue
// Small FIFO taking up to two words per cycle and giving one per cycle on out_take.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8u16_queue
   import u8u16_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire dec_result_type push_words,
   output logic                room,
   output logic                out_valid,
   input  wire logic           out_take,
   output rsp_word_type        out_word
);

   rsp_word_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic [1:0]            push_n;
   logic                  pop;
   logic [QPTR_W-1:0]     wr_ptr_next;

   assign push_n      = push ? push_words.count : 2'd0;
   assign pop         = out_valid && out_take;
   assign wr_ptr_next = wr_ptr_ff + QPTR_W'(1);

   // Room for a full two-word result
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_word  = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_words.first;
      end
      if (push_n == 2'd2) begin
         slot_ff[wr_ptr_next] <= push_words.second;
      end
   end

endmodule

`default_nettype wire

@@ rtl/utf8_to_utf16_transcoder_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit: UTF-8 to UTF-16 transcoder
// Byte in, UTF-16 code units and error words out.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle while the queue has room and returns
// UTF-16 code units, one per cycle while the result side is ready. Bytes
// are registered in the input register, decoded in a single pass, and the
// words (none, one, or a surrogate pair) are pushed into a four-word queue
// that drives the result channel. A byte is consumed whenever the queue has
// room for two words, so with the result side always ready the block
// sustains one byte per cycle; the single result port limits output to one
// word per cycle, so a stream of only pairs would stall, but a pair costs
// four input bytes. Invalid leads, bad continuations, surrogate or too large
// code points and sequences cut off by string_end each give one error word.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_transcoder_unit
   import u8u16_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   u8u16_req_if.sink   req_bus,
   u8u16_rsp_if.source rsp_bus
);

   logic           hold_valid_ff, hold_valid_in;
   logic [7:0]     hold_byte_ff;
   logic           hold_end_ff;
   logic           room;
   logic           step;
   dec_result_type result;
   rsp_word_type   head;

   // Input register: drains into the decoder when the queue has room
   assign step          = hold_valid_ff && room;
   assign req_bus.ready = !hold_valid_ff || room;
   assign hold_valid_in = req_bus.valid || (hold_valid_ff && !room);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         hold_byte_ff <= req_bus.in_byte;
         hold_end_ff  <= req_bus.string_end;
      end
   end

   u8u16_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .in_byte    (hold_byte_ff),
      .string_end (hold_end_ff),
      .result     (result)
   );

   u8u16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (step),
      .push_words (result),
      .room       (room),
      .out_valid  (rsp_bus.valid),
      .out_take   (rsp_bus.ready),
      .out_word   (head)
   );

   // Result channel payload
   assign rsp_bus.code_unit    = head.code_unit;
   assign rsp_bus.bad_sequence = head.bad_sequence;
   assign rsp_bus.run_last     = head.run_last;
   assign rsp_bus.string_done  = head.string_done;

endmodule

`default_nettype wire
